// ----- rtl/core/tsg_pkg.sv -----
// Package with the shared types and codes of the swipe gesture detector.
`timescale 1ns / 1ps
`default_nettype none

package tsg_pkg;

    // Field widths on the channels.
    localparam int ValW  = 16;
    localparam int ThrW  = 16;
    localparam int ReqW  = 2;
    localparam int GestW = 3;
    localparam int CfgIdxW = 1;

    typedef logic [ReqW-1:0]    t_req_type;
    typedef logic [GestW-1:0]   t_gesture;
    typedef logic [ThrW-1:0]    t_thr;
    typedef logic [CfgIdxW-1:0] t_cfg_idx;

    // Request types.
    localparam t_req_type REQ_X     = 2'd0;
    localparam t_req_type REQ_Y     = 2'd1;
    localparam t_req_type REQ_LEVEL = 2'd2;

    // Gesture codes.
    localparam t_gesture G_UP    = 3'd0;
    localparam t_gesture G_DOWN  = 3'd1;
    localparam t_gesture G_LEFT  = 3'd2;
    localparam t_gesture G_RIGHT = 3'd3;
    localparam t_gesture G_TAP   = 3'd4;
    localparam t_gesture G_NONE  = 3'd5;

    // Configuration register indexes and reset values.
    localparam t_cfg_idx CFG_SWIPE = 1'b0;
    localparam t_cfg_idx CFG_TAP   = 1'b1;
    localparam t_thr SWIPE_THR_RST = 16'd50;
    localparam t_thr TAP_THR_RST   = 16'd20;

endpackage

`default_nettype wire

// ----- rtl/core/tsg_if.sv -----
// Channel interfaces: touch event input, gesture result output, configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface tsg_req_if import tsg_pkg::*;;
    logic                   valid;
    logic                   ready;
    t_req_type              req_type;
    logic signed [ValW-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface tsg_res_if import tsg_pkg::*;;
    logic                   valid;
    logic                   ready;
    t_gesture               gesture;
    logic signed [ValW-1:0] end_x;
    logic signed [ValW-1:0] end_y;

    modport source (output valid, output gesture, output end_x, output end_y, input ready);
    modport sink   (input valid, input gesture, input end_x, input end_y, output ready);
endinterface

interface tsg_cfg_if import tsg_pkg::*;;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_thr     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tsg_classify.sv -----
// Gesture classifier: magnitudes, threshold compares and direction selection.
`timescale 1ns / 1ps
`default_nettype none

module tsg_classify import tsg_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  wire logic signed [COORD_BITS:0] i_d_rx,
    input  wire logic signed [COORD_BITS:0] i_d_ry,
    input  wire t_thr                       i_swipe_thr,
    input  wire t_thr                       i_tap_thr,
    output t_gesture                        o_gesture
);

    // Compare width covers both the magnitudes and the thresholds.
    localparam int CmpW = (COORD_BITS + 1 > ThrW) ? COORD_BITS + 1 : ThrW;

    logic [COORD_BITS:0] ax_raw;
    logic [COORD_BITS:0] ay_raw;
    logic [CmpW-1:0]     ax;
    logic [CmpW-1:0]     ay;
    logic [CmpW-1:0]     swipe_thr;
    logic [CmpW-1:0]     tap_thr;

    // Logical dx is minus the raw Y displacement, logical dy minus the raw X
    // displacement; the magnitudes are unaffected by the sign flip.
    assign ax_raw    = i_d_ry[COORD_BITS] ? (COORD_BITS+1)'(-i_d_ry) : i_d_ry;
    assign ay_raw    = i_d_rx[COORD_BITS] ? (COORD_BITS+1)'(-i_d_rx) : i_d_rx;
    assign ax        = CmpW'(ax_raw);
    assign ay        = CmpW'(ay_raw);
    assign swipe_thr = CmpW'(i_swipe_thr);
    assign tap_thr   = CmpW'(i_tap_thr);

    // Swipe on the larger axis (ties go vertical), then tap, else none.
    always_comb begin
        if (ax > swipe_thr || ay > swipe_thr) begin
            if (ax > ay) begin
                o_gesture = i_d_ry[COORD_BITS] ? G_RIGHT : G_LEFT;
            end else begin
                o_gesture = i_d_rx[COORD_BITS] ? G_DOWN : G_UP;
            end
        end else if (ax < tap_thr && ay < tap_thr) begin
            o_gesture = G_TAP;
        end else begin
            o_gesture = G_NONE;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/touch_swipe_gesture_detector.sv -----
// Top level of the touch swipe gesture detector.
//
// Usage: touch events enter on i_req (req_type: X update, Y update or touch
// level; value: coordinate or level). The block tracks the latest position
// and the start of the current touch. A falling touch level yields one
// result on o_res: the gesture code and the raw release position. All other
// events only update state and yield no result.
// Thresholds are written through i_cfg (index 0 swipe, index 1 tap); the
// user must write them only while the block is idle, which the block does
// not enforce; i_cfg is always ready. A release result passes through the
// displacement stage and is classified into the output register. One event
// is taken per cycle while i_req.ready is high.
// Reset clears position state, the touch level, the pipeline and sets the
// thresholds to 50 and 20. When the receiver stalls, the result holds in the
// output register; the displacement stage keeps taking events until both
// stages hold a result, and then i_req.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module touch_swipe_gesture_detector import tsg_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tsg_req_if.sink     i_req,
    tsg_cfg_if.sink     i_cfg,
    tsg_res_if.source   o_res
);

    // Tracking state.
    logic signed [COORD_BITS-1:0] r_cur_x;
    logic signed [COORD_BITS-1:0] r_cur_y;
    logic signed [COORD_BITS-1:0] r_start_x;
    logic signed [COORD_BITS-1:0] r_start_y;
    logic                         r_touching;
    t_thr                         r_swipe_thr;
    t_thr                         r_tap_thr;

    // Displacement stage.
    logic                         r_s1_valid;
    logic signed [COORD_BITS:0]   r_d_rx;
    logic signed [COORD_BITS:0]   r_d_ry;
    logic signed [COORD_BITS-1:0] r_s1_x;
    logic signed [COORD_BITS-1:0] r_s1_y;

    // Output register.
    logic                         r_out_valid;
    t_gesture                     r_gesture;
    logic signed [ValW-1:0]       r_end_x;
    logic signed [ValW-1:0]       r_end_y;

    logic                         req_xfer;
    logic                         out_adv;
    logic                         pressed;
    logic                         release_evt;
    logic signed [COORD_BITS:0]   n_d_rx;
    logic signed [COORD_BITS:0]   n_d_ry;
    t_gesture                     n_gesture;

    // Handshake: the output register frees when empty or taken, the
    // displacement stage when empty or moving on.
    assign out_adv     = !r_out_valid || o_res.ready;
    assign i_req.ready = !r_s1_valid || out_adv;
    assign req_xfer    = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    assign pressed     = (i_req.value != '0);
    assign release_evt = req_xfer && (i_req.req_type == REQ_LEVEL) && !pressed && r_touching;

    // Exact raw displacements, one bit wider than a coordinate.
    assign n_d_rx = {r_cur_x[COORD_BITS-1], r_cur_x} - {r_start_x[COORD_BITS-1], r_start_x};
    assign n_d_ry = {r_cur_y[COORD_BITS-1], r_cur_y} - {r_start_y[COORD_BITS-1], r_start_y};

    // Position and touch-level tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_touching <= 1'b0;
        end else if (req_xfer) begin
            case (i_req.req_type)
                REQ_X: begin
                    r_cur_x <= i_req.value[COORD_BITS-1:0];
                end
                REQ_Y: begin
                    r_cur_y <= i_req.value[COORD_BITS-1:0];
                end
                REQ_LEVEL: begin
                    if (pressed && !r_touching) begin
                        r_start_x <= r_cur_x;
                        r_start_y <= r_cur_y;
                    end
                    r_touching <= pressed;
                end
                default: begin
                end
            endcase
        end
    end

    // Threshold registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swipe_thr <= SWIPE_THR_RST;
            r_tap_thr   <= TAP_THR_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_SWIPE: r_swipe_thr <= i_cfg.data;
                CFG_TAP:   r_tap_thr   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Displacement stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= release_evt;
        end
    end

    // Displacement stage payload.
    always_ff @(posedge i_clk) begin
        if (release_evt) begin
            r_d_rx <= n_d_rx;
            r_d_ry <= n_d_ry;
            r_s1_x <= r_cur_x;
            r_s1_y <= r_cur_y;
        end
    end

    tsg_classify #(
        .COORD_BITS (COORD_BITS)
    ) u_classify (
        .i_d_rx      (r_d_rx),
        .i_d_ry      (r_d_ry),
        .i_swipe_thr (r_swipe_thr),
        .i_tap_thr   (r_tap_thr),
        .o_gesture   (n_gesture)
    );

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_valid) begin
            r_gesture <= n_gesture;
            r_end_x   <= ValW'(r_s1_x);
            r_end_y   <= ValW'(r_s1_y);
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.gesture = r_gesture;
    assign o_res.end_x   = r_end_x;
    assign o_res.end_y   = r_end_y;

    // A release transfer always fills the displacement stage.
    a_release_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        release_evt |=> r_s1_valid)
        else $error("release transfer did not reach the displacement stage");

    // The touch level only falls on a released-level transfer.
    a_touch_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_touching) |-> $past(req_xfer && i_req.req_type == REQ_LEVEL && !pressed))
        else $error("touch level fell without a released-level transfer");

    // A shown result always carries a defined gesture code.
    a_gesture_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_gesture <= G_NONE))
        else $error("result carries an undefined gesture code");

    // A held displacement result is not lost while the output stalls.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_adv) |=> r_s1_valid)
        else $error("displacement result dropped during a stall");

endmodule

`default_nettype wire

// ----- sim/touch_swipe_gesture_detector_test.sv -----
// Self-checking testbench of the touch swipe gesture detector: directed and random touch events.
`timescale 1ns / 1ps

module touch_swipe_gesture_detector_test import tsg_pkg::*;;

    localparam int        CoordBits  = 16;
    localparam int        IdleLimit  = 2000;
    localparam int        Settle     = 4;
    localparam int        ItemsPhase = 250;
    localparam int        NumPhases  = 8;
    localparam t_req_type ReqUnused  = 2'd3;

    // One touch event of the directed part, with its result typed in where it is obvious.
    typedef struct packed {
        t_req_type         kind;
        logic [15:0]       value;
        logic              typed;
        t_gesture          gesture;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
    } t_touch_row;

    typedef struct packed {
        t_gesture          gesture;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
    } t_gesture_result;

    localparam int NumRows = 28;
    localparam t_touch_row DirectedRows [NumRows] = '{
        // Press and release at the reset position: a tap at the origin.
        '{REQ_LEVEL, 16'h0001, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        '{REQ_LEVEL, 16'h0000, 1'b1, G_TAP,  16'sh0000, 16'sh0000},
        // A release while not touching yields nothing.
        '{REQ_LEVEL, 16'h0000, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        // Corner to corner: the exact difference of 65535 on both axes, a tie.
        '{REQ_X,     16'h7FFF, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        '{REQ_Y,     16'h8000, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        '{REQ_LEVEL, 16'h8000, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        '{REQ_LEVEL, 16'h0001, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        '{REQ_X,     16'h8000, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        '{REQ_Y,     16'h7FFF, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        '{REQ_LEVEL, 16'h0000, 1'b1, G_DOWN, 16'sh8000, 16'sh7FFF},
        // The unused request type is ignored.
        '{ReqUnused, 16'hFFFF, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        // Swipe right from the corner.
        '{REQ_LEVEL, 16'hFFFF, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        '{REQ_Y,     16'h7F9B, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        '{REQ_LEVEL, 16'h0000, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        // Swipe left just past the threshold.
        '{REQ_X,     16'h0000, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        '{REQ_Y,     16'h0000, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        '{REQ_LEVEL, 16'h0001, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        '{REQ_Y,     16'd51,   1'b0, G_NONE, 16'sh0000, 16'sh0000},
        '{REQ_LEVEL, 16'h0000, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        // Exactly at the swipe threshold and above the tap threshold: no gesture.
        '{REQ_LEVEL, 16'h0001, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        '{REQ_X,     16'd50,   1'b0, G_NONE, 16'sh0000, 16'sh0000},
        '{REQ_LEVEL, 16'h0000, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        // Swipe up.
        '{REQ_LEVEL, 16'h0001, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        '{REQ_X,     16'd101,  1'b0, G_NONE, 16'sh0000, 16'sh0000},
        '{REQ_LEVEL, 16'h0000, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        // Small move just under the tap threshold.
        '{REQ_LEVEL, 16'h0001, 1'b0, G_NONE, 16'sh0000, 16'sh0000},
        '{REQ_Y,     16'd32,   1'b0, G_NONE, 16'sh0000, 16'sh0000},
        '{REQ_LEVEL, 16'h0000, 1'b0, G_NONE, 16'sh0000, 16'sh0000}
    };

    logic i_clk;
    logic i_rst_n;

    tsg_req_if req_ch ();
    tsg_cfg_if cfg_ch ();
    tsg_res_if res_ch ();

    touch_swipe_gesture_detector #(
        .COORD_BITS(CoordBits)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_res   (res_ch.source)
    );

    // Predictor state: positions, touch level and thresholds.
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic signed [15:0] st_x;
    logic signed [15:0] st_y;
    logic               touching;
    int                 swipe_limit;
    int                 tap_limit;

    t_gesture_result    pending_gestures [$];
    int                 mismatch_count;
    int                 accepted_items;
    logic               sender_calm;
    int                 idle_cycles;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Keep the low coordinate bits of a raw value, sign-extended.
    function automatic logic signed [15:0] to_coord(logic [15:0] raw);
        logic signed [15:0] s;
        s = raw << (16 - CoordBits);
        return s >>> (16 - CoordBits);
    endfunction

    // Classify the current release with the rotated-display transform.
    function automatic t_gesture classify_release();
        int dx;
        int dy;
        int ax;
        int ay;
        dx = -(int'(cur_y) - int'(st_y));
        dy = -(int'(cur_x) - int'(st_x));
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax > swipe_limit || ay > swipe_limit) begin
            if (ax > ay) begin
                return (dx > 0) ? G_RIGHT : G_LEFT;
            end
            return (dy > 0) ? G_DOWN : G_UP;
        end
        if (ax < tap_limit && ay < tap_limit) begin
            return G_TAP;
        end
        return G_NONE;
    endfunction

    // Advance the predictor by one event; returns 1 when a gesture is reported.
    function automatic logic predict_touch_event(t_req_type kind, logic [15:0] val,
                                                 output t_gesture_result res);
        logic pressed;
        res = '0;
        case (kind)
            REQ_X: cur_x = to_coord(val);
            REQ_Y: cur_y = to_coord(val);
            REQ_LEVEL: begin
                pressed = (val != 16'h0000);
                if (pressed && !touching) begin
                    st_x     = cur_x;
                    st_y     = cur_y;
                    touching = 1'b1;
                end else if (!pressed && touching) begin
                    touching    = 1'b0;
                    res.gesture = classify_release();
                    res.end_x   = cur_x;
                    res.end_y   = cur_y;
                    return 1'b1;
                end else begin
                    touching = pressed;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic logic [15:0] clamp_coord(int v);
        if (v > 32767) begin
            v = 32767;
        end else if (v < -32768) begin
            v = -32768;
        end
        return v[15:0];
    endfunction

    // A coordinate drawn around a start position, often near one of the thresholds.
    function automatic logic [15:0] pick_coord(logic signed [15:0] base);
        int off;
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 65535));
            1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            2: off = int'($urandom_range(0, tap_limit + 2));
            3: off = swipe_limit + int'($urandom_range(0, 4)) - 2;
            default: off = int'($urandom_range(0, 300));
        endcase
        if ($urandom_range(0, 1)) begin
            off = -off;
        end
        return clamp_coord(int'(base) + off);
    endfunction

    // Drive one event, wait for its transfer and record what it should produce.
    task automatic send_event(t_req_type kind, logic [15:0] val,
                              logic typed, t_gesture_result typed_res);
        int              gap;
        t_gesture_result res;
        if ($urandom_range(0, 31) == 0) begin
            sender_calm = !sender_calm;
        end
        gap = sender_calm ? 0 : int'($urandom_range(0, 16));
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.value    <= val;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        if (kind != ReqUnused) begin
            accepted_items++;
        end
        if (predict_touch_event(kind, val, res)) begin
            pending_gestures.push_back(typed ? typed_res : res);
        end
    endtask

    task automatic send(t_req_type kind, logic [15:0] val);
        send_event(kind, val, 1'b0, '0);
    endtask

    // Hold the sender until every reported gesture has come out, then let the pipe settle.
    task automatic wait_for_results(int settle);
        req_ch.valid <= 1'b0;
        while (pending_gestures.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Write both thresholds in random order; only called while the block is idle.
    task automatic set_thresholds(t_thr swipe, t_thr tap);
        logic tap_first;
        tap_first = 1'($urandom_range(0, 1));
        for (int i = 0; i < 2; i++) begin
            cfg_ch.valid <= 1'b1;
            if ((i == 0) == tap_first) begin
                cfg_ch.index <= CFG_TAP;
                cfg_ch.data  <= tap;
            end else begin
                cfg_ch.index <= CFG_SWIPE;
                cfg_ch.data  <= swipe;
            end
            do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        end
        cfg_ch.valid <= 1'b0;
        swipe_limit = int'(swipe);
        tap_limit   = int'(tap);
    endtask

    // A well-formed touch: optional start position, press, a few moves, release.
    task automatic play_gesture();
        int off;
        if ($urandom_range(0, 1)) begin
            send(REQ_X, pick_coord(cur_x));
        end
        if ($urandom_range(0, 1)) begin
            send(REQ_Y, pick_coord(cur_y));
        end
        send(REQ_LEVEL, 16'($urandom_range(1, 65535)));
        if ($urandom_range(0, 7) == 0) begin
            // Equal distances on both axes.
            off = int'($urandom_range(0, swipe_limit + 2));
            send(REQ_X, clamp_coord(int'(st_x) + ($urandom_range(0, 1) ? off : -off)));
            send(REQ_Y, clamp_coord(int'(st_y) + ($urandom_range(0, 1) ? off : -off)));
        end else begin
            repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 1)) begin
                    send(REQ_X, pick_coord(st_x));
                end else begin
                    send(REQ_Y, pick_coord(st_y));
                end
            end
        end
        send(REQ_LEVEL, 16'h0000);
    endtask

    // Any event at all, including repeated levels and the unused request type.
    task automatic send_noise();
        t_req_type kind;
        kind = t_req_type'($urandom_range(0, 3));
        if (kind == REQ_LEVEL && $urandom_range(0, 1)) begin
            send(kind, 16'h0000);
        end else begin
            send(kind, 16'($urandom_range(0, 65535)));
        end
    endtask

    // Stimulus: reset, directed rows, then random phases under several thresholds.
    initial begin
        t_gesture_result typed_res;
        t_thr            swipe;
        t_thr            tap;
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_X;
        req_ch.value    = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_SWIPE;
        cfg_ch.data     = '0;
        cur_x           = '0;
        cur_y           = '0;
        st_x            = '0;
        st_y            = '0;
        touching        = 1'b0;
        swipe_limit     = int'(SWIPE_THR_RST);
        tap_limit       = int'(TAP_THR_RST);
        mismatch_count  = 0;
        accepted_items  = 0;
        sender_calm     = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DirectedRows[i]) begin
            typed_res.gesture = DirectedRows[i].gesture;
            typed_res.end_x   = DirectedRows[i].end_x;
            typed_res.end_y   = DirectedRows[i].end_y;
            send_event(DirectedRows[i].kind, DirectedRows[i].value,
                       DirectedRows[i].typed, typed_res);
        end
        wait_for_results(Settle);

        for (int phase = 0; phase < NumPhases; phase++) begin
            case (phase)
                0: begin swipe = 16'd0;     tap = 16'd0;     end
                1: begin swipe = 16'hFFFF;  tap = 16'hFFFF;  end
                2: begin swipe = 16'hFFFE;  tap = 16'd1;     end
                3: begin swipe = SWIPE_THR_RST; tap = TAP_THR_RST; end
                default: begin
                    swipe = 16'($urandom_range(0, 400));
                    tap   = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(0, swipe + 50));
                end
            endcase
            set_thresholds(swipe, tap);
            while (accepted_items < ItemsPhase * (phase + 1) + NumRows) begin
                if ($urandom_range(0, 99) == 0) begin
                    wait_for_results(Settle);
                end
                if ($urandom_range(0, 9) < 8) begin
                    play_gesture();
                end else begin
                    send_noise();
                end
            end
            wait_for_results(Settle);
        end

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("touch_swipe_gesture_detector verification clean");
        end else begin
            $display("touch_swipe_gesture_detector verification failed");
        end
        $finish;
    end

    // Result receiver: random stalls, then compare each transfer with the oldest expectation.
    initial begin
        t_gesture_result got;
        t_gesture_result want;
        int              stall;
        logic            calm;
        calm         = 1'b0;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                calm = !calm;
            end
            stall = calm ? 0 : int'($urandom_range(0, 16));
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
            got.gesture = res_ch.gesture;
            got.end_x   = res_ch.end_x;
            got.end_y   = res_ch.end_y;
            if (pending_gestures.size() == 0) begin
                $display("%0t: result with no expectation: gesture %0d end_x %0d end_y %0d",
                         $time, got.gesture, got.end_x, got.end_y);
                mismatch_count++;
            end else begin
                want = pending_gestures.pop_front();
                if (got.gesture !== want.gesture) begin
                    $display("%0t: gesture mismatch: expected %0d, actual %0d",
                             $time, want.gesture, got.gesture);
                    mismatch_count++;
                end
                if (got.end_x !== want.end_x) begin
                    $display("%0t: end_x mismatch: expected %0d, actual %0d",
                             $time, want.end_x, got.end_x);
                    mismatch_count++;
                end
                if (got.end_y !== want.end_y) begin
                    $display("%0t: end_y mismatch: expected %0d, actual %0d",
                             $time, want.end_y, got.end_y);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens on any channel for too long.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IdleLimit) begin
                $display("%0t: timeout with %0d results outstanding",
                         $time, pending_gestures.size());
                $display("touch_swipe_gesture_detector verification failed");
                $finish;
            end
        end
    end

endmodule

// ----- sim.f -----
rtl/core/tsg_pkg.sv
rtl/core/tsg_if.sv
rtl/core/tsg_classify.sv
rtl/core/touch_swipe_gesture_detector.sv
sim/touch_swipe_gesture_detector_test.sv
